/* src/ddm_pkg.sv */
// Package with shared constants, command/status types and the CORDIC arctangent table.
package ddm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 20;
  localparam int ITER_W         = 5;
  localparam int VEL_W          = 15;
  localparam int GAIN_Q15       = 19898;
  localparam int FULL_Q15       = 32768;
  localparam int MAX_SPEED_RST  = 500;
  localparam int RAMP_STEP_RST  = 16;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // capture a new command and seed the rotator
    logic              rotate;    // one CORDIC micro-rotation
    logic [ITER_W-1:0] iter;      // current micro-rotation index
    logic              map;       // quadrant map, sum/difference and clamp
    logic              mul_left;  // multiply left ratio by max speed
    logic              mul_right; // store left target, multiply right ratio
    logic              rnd_right; // store right target
    logic              tick;      // apply one ramp step to both wheels
  } ddm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register can take a new transaction
  } ddm_status_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/ddm_ctrl.sv */
// Controller state machine that sequences the mixer datapath.
module ddm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             kind,
  output logic             in_stall,
  input  ddm_pkg::ddm_status_t status,
  output ddm_pkg::ddm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROTATE, S_MAP, S_MUL_L, S_MUL_R, S_RND_R, S_TICK
  } state_t;

  state_t                    state;
  logic [ddm_pkg::ITER_W-1:0] iter;
  logic                      accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Decode commands from the current state.
  always_comb begin
    cmd           = '0;
    cmd.load      = accept && !kind;
    cmd.rotate    = (state == S_ROTATE);
    cmd.iter      = iter;
    cmd.map       = (state == S_MAP);
    cmd.mul_left  = (state == S_MUL_L);
    cmd.mul_right = (state == S_MUL_R);
    cmd.rnd_right = (state == S_RND_R);
    cmd.tick      = (state == S_TICK) && status.slot_free;
  end

  // State and iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          iter <= '0;
          if (accept) state <= kind ? S_TICK : S_ROTATE;
        end
        S_ROTATE: begin
          iter <= iter + 1'b1;
          if (iter == ddm_pkg::ITER_W'(ddm_pkg::CORDIC_STEPS - 1)) state <= S_MAP;
        end
        S_MAP:   state <= S_MUL_L;
        S_MUL_L: state <= S_MUL_R;
        S_MUL_R: state <= S_RND_R;
        S_RND_R: state <= S_IDLE;
        S_TICK: begin
          if (status.slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/ddm_datapath.sv */
// Datapath: CORDIC rotator, wheel mixing, target scaling, velocity ramp and output register.
module ddm_datapath #(
  parameter int ANGLE_BITS = ddm_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ddm_pkg::ddm_cmd_t                cmd,
  output ddm_pkg::ddm_status_t             status,
  input  logic [15:0]                      speed_fraction,
  input  logic [15:0]                      heading,
  input  logic                             cfg_valid,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ddm_pkg::VEL_W-1:0] left_velocity,
  output logic signed [ddm_pkg::VEL_W-1:0] right_velocity,
  output logic                             left_updated,
  output logic                             right_updated
);

  localparam int VW = ddm_pkg::VEL_W;
  // Angle bits below the kept resolution are dropped.
  localparam logic [31:0] ZMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // Configuration registers.
  logic [9:0]  max_speed;
  logic [13:0] ramp_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 10'(ddm_pkg::MAX_SPEED_RST);
      ramp_step <= 14'(ddm_pkg::RAMP_STEP_RST);
    end else if (cfg_valid) begin
      if (cfg_index == ddm_pkg::REG_MAX_SPEED) max_speed <= cfg_data[9:0];
      else if (cfg_index == ddm_pkg::REG_RAMP_STEP) ramp_step <= cfg_data[13:0];
    end
  end

  // CORDIC rotator.
  logic signed [33:0] x, y, z;
  logic [1:0]         quad;
  logic [15:0]        rho;
  logic [30:0]        x_seed;
  logic [31:0]        z_seed;
  logic signed [33:0] dx, dy, atn;

  assign rho    = (speed_fraction > 16'(ddm_pkg::FULL_Q15)) ?
                  16'(ddm_pkg::FULL_Q15) : speed_fraction;
  assign x_seed = 31'(rho) * 31'(ddm_pkg::GAIN_Q15);
  assign z_seed = {2'b00, heading[13:0], 16'b0} & ZMASK;
  assign dx     = y >>> cmd.iter;
  assign dy     = x >>> cmd.iter;
  assign atn    = signed'({2'b00, ddm_pkg::atan_turn(cmd.iter)});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= signed'({3'b000, x_seed});
      y    <= '0;
      z    <= signed'({2'b00, z_seed});
      quad <= heading[15:14];
    end else if (cmd.rotate) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atn;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atn;
      end
    end
  end

  // Quadrant map, sum and difference, clamp to plus or minus one in Q30.
  logic signed [34:0] xr, yr, diff, sum;
  logic signed [31:0] ratio_l, ratio_r;

  function automatic logic signed [31:0] clamp_unit(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd1073741824) r = 32'sd1073741824;
    else if (v < -35'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    unique case (quad)
      2'd0: begin xr = 35'(x);  yr = 35'(y);  end
      2'd1: begin xr = -35'(y); yr = 35'(x);  end
      2'd2: begin xr = -35'(x); yr = -35'(y); end
      default: begin xr = 35'(y); yr = -35'(x); end
    endcase
    diff = xr - yr;
    sum  = xr + yr;
  end

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      ratio_l <= clamp_unit(diff);
      ratio_r <= clamp_unit(sum);
    end
  end

  // Shared multiplier and rounding to nearest, ties away from zero.
  logic signed [42:0] prod;
  logic signed [31:0] mul_a;
  logic [42:0]        mag, mag_rnd;
  logic signed [VW-1:0] rnd_target;

  assign mul_a   = cmd.mul_right ? ratio_r : ratio_l;
  assign mag     = prod[42] ? 43'(-prod) : 43'(prod);
  assign mag_rnd = mag + (43'd1 << 25);
  assign rnd_target = prod[42] ? -signed'(mag_rnd[26+VW-1:26]) : signed'(mag_rnd[26+VW-1:26]);

  always_ff @(posedge clk) begin
    if (cmd.mul_left || cmd.mul_right) prod <= 43'(mul_a) * signed'(43'({1'b0, max_speed}));
  end

  // Wheel targets and current velocities.
  logic signed [VW-1:0] left_target, right_target, left_current, right_current;
  logic signed [VW-1:0] left_ramped, right_ramped;
  logic [13:0]          step;
  logic                 lu, ru;

  function automatic logic signed [VW-1:0] ramp(input logic signed [VW-1:0] cur,
                                               input logic signed [VW-1:0] tgt,
                                               input logic [13:0] st);
    logic signed [VW+1:0] d, s;
    logic signed [VW-1:0] r;
    s = signed'((VW+2)'(st));
    if (tgt > cur) begin
      d = (VW+2)'(tgt) - (VW+2)'(cur);
      r = (d > s) ? VW'((VW+2)'(cur) + s) : tgt;
    end else begin
      d = (VW+2)'(cur) - (VW+2)'(tgt);
      r = (d > s) ? VW'((VW+2)'(cur) - s) : tgt;
    end
    return r;
  endfunction

  assign step         = (ramp_step == 14'd0) ? 14'd1 : ramp_step;
  assign lu           = left_current != left_target;
  assign ru           = right_current != right_target;
  assign left_ramped  = ramp(left_current, left_target, step);
  assign right_ramped = ramp(right_current, right_target, step);
  assign status.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_target   <= '0;
      right_target  <= '0;
      left_current  <= '0;
      right_current <= '0;
    end else begin
      if (cmd.mul_right) left_target <= rnd_target;
      if (cmd.rnd_right) right_target <= rnd_target;
      if (cmd.tick) begin
        if (lu) left_current <= left_ramped;
        if (ru) right_current <= right_ramped;
      end
    end
  end

  // Output register: one transaction per tick that moved a wheel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tick && (lu || ru)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick && (lu || ru)) begin
      left_velocity  <= lu ? left_ramped : left_current;
      right_velocity <= ru ? right_ramped : right_current;
      left_updated   <= lu;
      right_updated  <= ru;
    end
  end

endmodule

/* src/diff_drive_mixer_with_ramp.sv */
// Top level of the differential-drive mixer with velocity ramp.
// A motion command is accepted, then runs 20 CORDIC micro-rotations on one shared
// shift-add unit, a mixing/clamp step and left/right scaling on one shared multiplier.
// A tick is accepted, then ramps both wheels, waiting only while the output is stalled.
// Input is taken one transaction at a time; results sit in an output register.
// Synchronous reset clears targets and velocities to zero and loads default registers.
module diff_drive_mixer_with_ramp #(
  parameter int ANGLE_BITS = ddm_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [15:0]                      speed_fraction,
  input  logic [15:0]                      heading,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ddm_pkg::VEL_W-1:0] left_velocity,
  output logic signed [ddm_pkg::VEL_W-1:0] right_velocity,
  output logic                             left_updated,
  output logic                             right_updated
);

  ddm_pkg::ddm_cmd_t    cmd;
  ddm_pkg::ddm_status_t status;

  assign cfg_ready = 1'b1;

  ddm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ddm_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .speed_fraction (speed_fraction),
    .heading        (heading),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_velocity  (left_velocity),
    .right_velocity (right_velocity),
    .left_updated   (left_updated),
    .right_updated  (right_updated)
  );

endmodule

/* src/ddm_checker.sv */
// Port-level checker for the mixer, attached to the top level by bind.
module ddm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic kind,
  input logic out_valid,
  input logic out_stall,
  input logic left_updated,
  input logic right_updated,
  input logic signed [ddm_pkg::VEL_W-1:0] left_velocity
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // A stalled result keeps its left velocity.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(left_velocity)) else $error("stalled result changed");

  // Every result reports at least one moved wheel.
  a_some_update: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_updated || right_updated)) else $error("result without update");

  // An accepted motion command keeps the input stalled in the cycle after.
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !kind |=> in_stall) else $error("command not sequenced");

endmodule

bind diff_drive_mixer_with_ramp ddm_checker u_ddm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .kind          (kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .left_updated  (left_updated),
  .right_updated (right_updated),
  .left_velocity (left_velocity)
);

/* tb/diff_drive_mixer_with_ramp_tb.sv */
// Self-checking testbench for the differential-drive mixer with velocity ramp.
module diff_drive_mixer_with_ramp_tb;

  localparam int ANG = ddm_pkg::ANGLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;
  // A register index that the block does not implement.
  localparam logic [ddm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  typedef struct {
    bit        kind;
    bit [15:0] speed;
    bit [15:0] head;
  } motion_item_t;

  typedef struct {
    logic signed [ddm_pkg::VEL_W-1:0] left_vel;
    logic signed [ddm_pkg::VEL_W-1:0] right_vel;
    bit                               left_upd;
    bit                               right_upd;
  } wheel_state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ATAN_TURN[ddm_pkg::CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [15:0] speed_fraction = '0;
  logic [15:0] heading = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ddm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ddm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ddm_pkg::VEL_W-1:0] left_velocity;
  logic signed [ddm_pkg::VEL_W-1:0] right_velocity;
  logic left_updated;
  logic right_updated;

  diff_drive_mixer_with_ramp dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .speed_fraction(speed_fraction), .heading(heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_velocity(left_velocity), .right_velocity(right_velocity),
    .left_updated(left_updated), .right_updated(right_updated)
  );

  always #2 clk = ~clk;

  // Predictor state and configuration copy.
  longint       full_speed;
  longint       slew_step;
  longint       tgt_l, tgt_r, vel_l, vel_r;
  motion_item_t cmd_backlog[$];
  wheel_state_t wheel_expect[$];
  motion_item_t next_item;
  int           send_pct = 0;
  int           recv_pct = 0;
  int           errors = 0;
  int           cycles = 0;

  function automatic longint scale_ratio(input longint ratio);
    longint p, mag, q;
    if (ratio > (64'sd1 << 30)) ratio = 64'sd1 << 30;
    if (ratio < -(64'sd1 << 30)) ratio = -(64'sd1 << 30);
    p = ratio * full_speed;
    mag = (p < 0) ? -p : p;
    q = (mag + (64'sd1 << 25)) >>> 26;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint ramp_toward(input longint cur, input longint tgt,
                                         input longint step);
    if (tgt > cur) return (tgt - cur > step) ? cur + step : tgt;
    return (cur - tgt > step) ? cur - step : tgt;
  endfunction

  // Rotate the speed vector by the heading and derive both wheel targets.
  task automatic mix_targets(input bit [15:0] sf, input bit [15:0] hd);
    longint rho, a, r, z, x, y, dx, dy, xr, yr;
    int quad;
    rho = (sf > ddm_pkg::FULL_Q15) ? ddm_pkg::FULL_Q15 : sf;
    a = (longint'(hd) << 8) >> (24 - ANG);
    quad = int'((a >> (ANG - 2)) & 3);
    r = a & ((64'sd1 << (ANG - 2)) - 1);
    z = r << (32 - ANG);
    x = rho * ddm_pkg::GAIN_Q15;
    y = 0;
    for (int i = 0; i < ddm_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    case (quad)
      0: begin xr = x;  yr = y;  end
      1: begin xr = -y; yr = x;  end
      2: begin xr = -x; yr = -y; end
      default: begin xr = y; yr = -x; end
    endcase
    tgt_l = scale_ratio(xr - yr);
    tgt_r = scale_ratio(xr + yr);
  endtask

  // Update the predictor with one accepted transaction.
  task automatic mixer_apply(input motion_item_t it);
    wheel_state_t w;
    longint step;
    if (!it.kind) begin
      mix_targets(it.speed, it.head);
    end else begin
      step = (slew_step == 0) ? 1 : slew_step;
      w.left_upd = (vel_l != tgt_l);
      w.right_upd = (vel_r != tgt_r);
      if (w.left_upd) vel_l = ramp_toward(vel_l, tgt_l, step);
      if (w.right_upd) vel_r = ramp_toward(vel_r, tgt_r, step);
      if (w.left_upd || w.right_upd) begin
        w.left_vel = vel_l[ddm_pkg::VEL_W-1:0];
        w.right_vel = vel_r[ddm_pkg::VEL_W-1:0];
        wheel_expect.push_back(w);
      end
    end
  endtask

  // Input driver: holds a stalled transaction, otherwise loads or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_item.kind = kind;
        next_item.speed = speed_fraction;
        next_item.head = heading;
        mixer_apply(next_item);
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
          next_item = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          kind <= next_item.kind;
          speed_fraction <= next_item.speed;
          heading <= next_item.head;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
      if (out_valid && !out_stall) begin
        if (wheel_expect.size() == 0) begin
          if (errors < 10) $display("unexpected result: left %0d right %0d",
                                    left_velocity, right_velocity);
          errors <= errors + 1;
        end else begin
          if (left_velocity !== wheel_expect[0].left_vel ||
              right_velocity !== wheel_expect[0].right_vel ||
              left_updated !== wheel_expect[0].left_upd ||
              right_updated !== wheel_expect[0].right_upd) begin
            if (errors < 10)
              $display("mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                       wheel_expect[0].left_vel, wheel_expect[0].right_vel,
                       wheel_expect[0].left_upd, wheel_expect[0].right_upd,
                       left_velocity, right_velocity, left_updated, right_updated);
            errors <= errors + 1;
          end
          void'(wheel_expect.pop_front());
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("diff_drive_mixer_with_ramp_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_item(input bit k, input bit [15:0] sf, input bit [15:0] hd);
    motion_item_t it;
    it.kind = k;
    it.speed = sf;
    it.head = hd;
    cmd_backlog.push_back(it);
  endtask

  // Random traffic: commands with random content, each followed by a run of ticks.
  task automatic queue_random(input int n);
    int count;
    bit [15:0] sf;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 99) < 60) begin
        sf = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 32768))
                                          : 16'($urandom_range(0, 65535));
        queue_item(1'b0, sf, 16'($urandom_range(0, 65535)));
        count++;
      end
      repeat ($urandom_range(1, 6)) begin
        queue_item(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        count++;
      end
    end
  endtask

  // Wait until the block has drained and all results have arrived.
  task automatic wait_drained;
    while (cmd_backlog.size() != 0 || in_valid || wheel_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ddm_pkg::REG_MAX_SPEED) full_speed = val & 16'h03FF;
    else if (idx == ddm_pkg::REG_RAMP_STEP) slew_step = val & 16'h3FFF;
  endtask

  int ms_set[6] = '{1000, 1, 0, 777, 1000, 500};
  int rs_set[6] = '{16000, 0, 1, 16000, 300, 2500};

  initial begin
    full_speed = ddm_pkg::MAX_SPEED_RST;
    slew_step = ddm_pkg::RAMP_STEP_RST;
    tgt_l = 0; tgt_r = 0; vel_l = 0; vel_r = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_pct = 23;
    recv_pct = 53;

    // An unknown register index must leave both registers alone.
    write_reg(REG_UNUSED, 16'hFFFF);

    // Directed: axis headings, saturated and zero speed, default registers.
    queue_item(1'b0, 16'd32768, 16'd0);     queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd65535, 16'd16384); queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd0, 16'd0);         queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd32768, 16'd8192);  queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd32768, 16'd32768); queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd20000, 16'd49152); queue_item(1'b0, 16'd20000, 16'd49152);
    queue_item(1'b1, 16'hFFFF, 16'hFFFF);   queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd32768, 16'd65535); queue_item(1'b1, 0, 0);
    queue_item(1'b0, 16'd16384, 16'd24576); queue_item(1'b1, 0, 0); queue_item(1'b1, 0, 0);
    wait_drained();

    // Random part over six register settings and three idling profiles.
    for (int k = 0; k < 6; k++) begin
      if (k == 2) begin
        send_pct = 53;
        recv_pct = 23;
      end else if (k == 4) begin
        send_pct = 0;
        recv_pct = 0;
      end
      // Upper data bits beyond the register width are dropped.
      write_reg(ddm_pkg::REG_MAX_SPEED,
                (k == 1) ? 16'(ms_set[k] | 16'hFC00) : 16'(ms_set[k]));
      write_reg(ddm_pkg::REG_RAMP_STEP, 16'(rs_set[k]));
      queue_random(108);
      wait_drained();
    end

    if (errors == 0)
      $display("diff_drive_mixer_with_ramp_tb OK");
    else
      $display("diff_drive_mixer_with_ramp_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
src/ddm_pkg.sv
src/ddm_ctrl.sv
src/ddm_datapath.sv
src/diff_drive_mixer_with_ramp.sv
src/ddm_checker.sv
tb/diff_drive_mixer_with_ramp_tb.sv
